FILE: sv/repetition_counter_energy_accumulator_unit_macros.svh
// Assertion macros; they expect clk and rst_n in the scope of use.
`ifndef REPETITION_COUNTER_ENERGY_ACCUMULATOR_UNIT_MACROS_SVH
`define REPETITION_COUNTER_ENERGY_ACCUMULATOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define RCEA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RCEA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/rcea_pkg.sv
`timescale 1ns / 1ps

package rcea_pkg;

  localparam int NUM_REGS   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int LIMIT_W   = 16;
  localparam int DB_W      = 10;
  localparam int MASS_W    = 14;
  localparam int ACCEL_W   = 15;
  localparam int COEF_W    = 16;
  localparam int COEF_FRAC = 8;
  localparam int REP_W     = 16;
  localparam int HALF_W    = 17;

  typedef logic [REP_W-1:0]  rep_t;
  typedef logic [HALF_W-1:0] half_t;

  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_HIGH_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_LOW_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_MASS      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_ACCEL  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DOWN_COEF      = 3'd7;

  localparam logic signed [LIMIT_W-1:0] HIGH_LIMIT_RST     = 16'sd500;
  localparam logic signed [LIMIT_W-1:0] LOW_LIMIT_RST      = 16'sd100;
  localparam logic signed [LIMIT_W-1:0] VEL_HIGH_LIMIT_RST = 16'sd300;
  localparam logic signed [LIMIT_W-1:0] VEL_LOW_LIMIT_RST  = 16'sd50;
  localparam logic [DB_W-1:0]           DEAD_BAND_RST      = 10'd20;
  localparam logic [MASS_W-1:0]         LOAD_MASS_RST      = 14'd200;
  localparam logic [ACCEL_W-1:0]        GRAVITY_ACCEL_RST  = 15'd9810;
  localparam logic [COEF_W-1:0]         DOWN_COEF_RST      = 16'd256;

  localparam rep_t  REP_MAX  = '1;
  localparam half_t HALF_MAX = '1;

  localparam logic OP_DISTANCE = 1'b0;
  localparam logic OP_VELOCITY = 1'b1;

endpackage

FILE: sv/rcea_if.sv
`timescale 1ns / 1ps

interface rcea_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic                           op;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output op, output sample, input ready);
  modport sink   (input valid, input op, input sample, output ready);
endinterface

interface rcea_out_if #(
  parameter int ENERGY_WIDTH = 48
);
  logic                    valid;
  logic                    ready;
  rcea_pkg::rep_t          repetitions;
  logic [ENERGY_WIDTH-1:0] energy;
  logic                    up_flag;

  modport source (output valid, output repetitions, output energy, output up_flag,
                  input ready);
  modport sink   (input valid, input repetitions, input energy, input up_flag,
                  output ready);
endinterface

FILE: sv/repetition_counter_energy_accumulator_unit.sv
// Channel  Dir  Handshake     Beat payload
// in_ch    in   valid/ready   op, sample
// out_ch   out  valid/ready   repetitions, energy, up_flag
// cfg_*    in   cfg_we        cfg_index, cfg_data
//
// One beat at a time. Without an energy update the beat passes ST_EVAL and then ST_DONE,
// where the result register loads once out_ch can take it. A move past the dead band runs
// the shared shift-add unit, one multiplier bit per cycle, over accel, step magnitude and
// (lowering) coefficient bits.
// Synchronous rst_n restores the register defaults and clears counters, energy, flag.
// A valid result holds while out_ch.ready is low; in_ch.ready is high only when idle.
`timescale 1ns / 1ps

`include "repetition_counter_energy_accumulator_unit_macros.svh"

module repetition_counter_energy_accumulator_unit #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int ENERGY_WIDTH = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  rcea_in_if.sink                           in_ch,
  rcea_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [rcea_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rcea_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CMP_W = (SAMPLE_WIDTH > rcea_pkg::LIMIT_W) ? SAMPLE_WIDTH
                                                            : rcea_pkg::LIMIT_W;
  localparam int MAG_CMP_W = (SAMPLE_WIDTH > rcea_pkg::DB_W) ? SAMPLE_WIDTH
                                                             : rcea_pkg::DB_W;
  localparam int MB_W = (SAMPLE_WIDTH > rcea_pkg::COEF_W) ? SAMPLE_WIDTH
                                                          : rcea_pkg::COEF_W;
  localparam int ACC_W = rcea_pkg::MASS_W + rcea_pkg::ACCEL_W + SAMPLE_WIDTH
                         + rcea_pkg::COEF_W;
  localparam int WIDE_W = ACC_W + ENERGY_WIDTH;

  localparam int ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE     = 3'd0;
  localparam logic [ST_W-1:0] ST_EVAL     = 3'd1;
  localparam logic [ST_W-1:0] ST_MUL_MA   = 3'd2;
  localparam logic [ST_W-1:0] ST_MUL_MAG  = 3'd3;
  localparam logic [ST_W-1:0] ST_MUL_COEF = 3'd4;
  localparam logic [ST_W-1:0] ST_ENERGY   = 3'd5;
  localparam logic [ST_W-1:0] ST_DONE     = 3'd6;

  logic signed [rcea_pkg::LIMIT_W-1:0] high_r, low_r, vhigh_r, vlow_r;
  logic [rcea_pkg::DB_W-1:0]           db_r;
  logic [rcea_pkg::MASS_W-1:0]         mass_r;
  logic [rcea_pkg::ACCEL_W-1:0]        accel_r;
  logic [rcea_pkg::COEF_W-1:0]         coef_r;

  logic [ST_W-1:0]                state_r, state_nxt;
  logic                           op_r, op_nxt;
  logic signed [SAMPLE_WIDTH-1:0] sample_r, sample_nxt;
  logic signed [SAMPLE_WIDTH-1:0] last_r, last_nxt;
  logic [ENERGY_WIDTH-1:0]        energy_r, energy_nxt;
  rcea_pkg::rep_t                 rep_r, rep_nxt;
  rcea_pkg::half_t                half_r, half_nxt;
  logic                           above_r, above_nxt;
  logic                           down_r, down_nxt;
  logic [SAMPLE_WIDTH-1:0]        mag_r, mag_nxt;
  logic [ACC_W-1:0]               mul_a_r, mul_a_nxt;
  logic [MB_W-1:0]                mul_b_r, mul_b_nxt;
  logic [ACC_W-1:0]               acc_r, acc_nxt;
  logic                           out_valid_r, out_valid_nxt;
  rcea_pkg::rep_t                 out_rep_r, out_rep_nxt;
  logic [ENERGY_WIDTH-1:0]        out_energy_r, out_energy_nxt;
  logic                           out_flag_r, out_flag_nxt;

  logic signed [CMP_W-1:0]        s_cmp, hi_cmp, lo_cmp;
  logic signed [SAMPLE_WIDTH:0]   step;
  logic signed [SAMPLE_WIDTH:0]   mag_full;
  logic [SAMPLE_WIDTH-1:0]        mag;
  logic                           move;
  logic                           rise, flag_up, fall;
  rcea_pkg::half_t                half_new;
  logic [ACC_W-1:0]               mul_step_acc;
  logic                           mul_done;
  logic [WIDE_W-1:0]              amt_wide;
  logic [ENERGY_WIDTH-1:0]        amt_sat;
  logic [ENERGY_WIDTH:0]          energy_sum;
  logic [ENERGY_WIDTH-1:0]        energy_new;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_r  <= rcea_pkg::HIGH_LIMIT_RST;
      low_r   <= rcea_pkg::LOW_LIMIT_RST;
      vhigh_r <= rcea_pkg::VEL_HIGH_LIMIT_RST;
      vlow_r  <= rcea_pkg::VEL_LOW_LIMIT_RST;
      db_r    <= rcea_pkg::DEAD_BAND_RST;
      mass_r  <= rcea_pkg::LOAD_MASS_RST;
      accel_r <= rcea_pkg::GRAVITY_ACCEL_RST;
      coef_r  <= rcea_pkg::DOWN_COEF_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rcea_pkg::REG_HIGH_LIMIT:     high_r  <= cfg_data;
        rcea_pkg::REG_LOW_LIMIT:      low_r   <= cfg_data;
        rcea_pkg::REG_VEL_HIGH_LIMIT: vhigh_r <= cfg_data;
        rcea_pkg::REG_VEL_LOW_LIMIT:  vlow_r  <= cfg_data;
        rcea_pkg::REG_DEAD_BAND:      db_r    <= cfg_data[rcea_pkg::DB_W-1:0];
        rcea_pkg::REG_LOAD_MASS:      mass_r  <= cfg_data[rcea_pkg::MASS_W-1:0];
        rcea_pkg::REG_GRAVITY_ACCEL:  accel_r <= cfg_data[rcea_pkg::ACCEL_W-1:0];
        rcea_pkg::REG_DOWN_COEF:      coef_r  <= cfg_data[rcea_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Hysteresis and dead band
  assign s_cmp  = CMP_W'(sample_r);
  assign hi_cmp = CMP_W'((op_r == rcea_pkg::OP_VELOCITY) ? vhigh_r : high_r);
  assign lo_cmp = CMP_W'((op_r == rcea_pkg::OP_VELOCITY) ? vlow_r : low_r);

  assign rise    = !above_r && (s_cmp >= hi_cmp);
  assign flag_up = above_r || rise;
  assign fall    = flag_up && (s_cmp <= lo_cmp);

  assign half_new = (rise && (half_r != rcea_pkg::HALF_MAX))
                    ? half_r + rcea_pkg::HALF_W'(1) : half_r;

  assign step     = (SAMPLE_WIDTH + 1)'(sample_r) - (SAMPLE_WIDTH + 1)'(last_r);
  assign mag_full = step[SAMPLE_WIDTH] ? -step : step;
  assign mag      = mag_full[SAMPLE_WIDTH-1:0];
  assign move     = MAG_CMP_W'(mag) > MAG_CMP_W'(db_r);

  // Shared shift-add multiplier step
  assign mul_done     = (mul_b_r == '0);
  assign mul_step_acc = mul_b_r[0] ? acc_r + mul_a_r : acc_r;

  // Saturating energy update
  assign amt_wide   = WIDE_W'(acc_r);
  assign amt_sat    = (amt_wide > WIDE_W'({ENERGY_WIDTH{1'b1}})) ? {ENERGY_WIDTH{1'b1}}
                                                                  : amt_wide[ENERGY_WIDTH-1:0];
  assign energy_sum = (ENERGY_WIDTH + 1)'(energy_r) + (ENERGY_WIDTH + 1)'(amt_sat);
  assign energy_new = energy_sum[ENERGY_WIDTH] ? {ENERGY_WIDTH{1'b1}}
                                               : energy_sum[ENERGY_WIDTH-1:0];

  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    sample_nxt     = sample_r;
    last_nxt       = last_r;
    energy_nxt     = energy_r;
    rep_nxt        = rep_r;
    half_nxt       = half_r;
    above_nxt      = above_r;
    down_nxt       = down_r;
    mag_nxt        = mag_r;
    mul_a_nxt      = mul_a_r;
    mul_b_nxt      = mul_b_r;
    acc_nxt        = acc_r;
    out_valid_nxt  = out_valid_r;
    out_rep_nxt    = out_rep_r;
    out_energy_nxt = out_energy_r;
    out_flag_nxt   = out_flag_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt     = in_ch.op;
          sample_nxt = in_ch.sample;
          state_nxt  = ST_EVAL;
        end
      end
      ST_EVAL: begin
        above_nxt = flag_up && !fall;
        if (op_r == rcea_pkg::OP_DISTANCE) begin
          if (rise && (rep_r != rcea_pkg::REP_MAX)) begin
            rep_nxt = rep_r + rcea_pkg::REP_W'(1);
          end
          if (move) begin
            last_nxt  = sample_r;
            down_nxt  = step[SAMPLE_WIDTH];
            mag_nxt   = mag;
            mul_a_nxt = ACC_W'(mass_r);
            mul_b_nxt = MB_W'(accel_r);
            acc_nxt   = '0;
            state_nxt = ST_MUL_MA;
          end else begin
            state_nxt = ST_DONE;
          end
        end else begin
          half_nxt  = half_new;
          rep_nxt   = half_new[rcea_pkg::HALF_W-1:1];
          state_nxt = ST_DONE;
        end
      end
      ST_MUL_MA: begin
        if (mul_done) begin
          mul_a_nxt = acc_r;
          mul_b_nxt = MB_W'(mag_r);
          acc_nxt   = '0;
          state_nxt = ST_MUL_MAG;
        end else begin
          acc_nxt   = mul_step_acc;
          mul_a_nxt = mul_a_r << 1;
          mul_b_nxt = mul_b_r >> 1;
        end
      end
      ST_MUL_MAG: begin
        if (mul_done) begin
          if (down_r) begin
            mul_a_nxt = acc_r;
            mul_b_nxt = MB_W'(coef_r);
            acc_nxt   = '0;
            state_nxt = ST_MUL_COEF;
          end else begin
            state_nxt = ST_ENERGY;
          end
        end else begin
          acc_nxt   = mul_step_acc;
          mul_a_nxt = mul_a_r << 1;
          mul_b_nxt = mul_b_r >> 1;
        end
      end
      ST_MUL_COEF: begin
        if (mul_done) begin
          acc_nxt   = acc_r >> rcea_pkg::COEF_FRAC;
          state_nxt = ST_ENERGY;
        end else begin
          acc_nxt   = mul_step_acc;
          mul_a_nxt = mul_a_r << 1;
          mul_b_nxt = mul_b_r >> 1;
        end
      end
      ST_ENERGY: begin
        energy_nxt = energy_new;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_rep_nxt    = rep_r;
          out_energy_nxt = energy_r;
          out_flag_nxt   = above_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      last_r      <= '0;
      energy_r    <= '0;
      rep_r       <= '0;
      half_r      <= '0;
      above_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_r      <= last_nxt;
      energy_r    <= energy_nxt;
      rep_r       <= rep_nxt;
      half_r      <= half_nxt;
      above_r     <= above_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    sample_r     <= sample_nxt;
    down_r       <= down_nxt;
    mag_r        <= mag_nxt;
    mul_a_r      <= mul_a_nxt;
    mul_b_r      <= mul_b_nxt;
    acc_r        <= acc_nxt;
    out_rep_r    <= out_rep_nxt;
    out_energy_r <= out_energy_nxt;
    out_flag_r   <= out_flag_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.repetitions = out_rep_r;
  assign out_ch.energy      = out_energy_r;
  assign out_ch.up_flag     = out_flag_r;

  `RCEA_ASSERT_NEXT(a_energy_no_drop, rst_n, energy_r >= $past(energy_r), "energy dropped")
  `RCEA_ASSERT_NEXT(a_rep_single_step, rst_n && state_r == ST_EVAL && op_r == rcea_pkg::OP_DISTANCE, (rep_r - $past(rep_r)) <= rcea_pkg::REP_W'(1), "rep count jumped")
  `RCEA_ASSERT_NOW(a_coef_only_down, state_r == ST_MUL_COEF, down_r, "coefficient pass on rising move")
  `RCEA_ASSERT_NEXT(a_last_hold, rst_n && state_r != ST_EVAL, last_r == $past(last_r), "kept distance changed")

endmodule

FILE: tb/tb_repetition_counter_energy_accumulator_unit.sv
`timescale 1ns / 1ps

localparam int TB_SAMPLE_W = 16;
localparam int TB_ENERGY_W = 48;
localparam longint unsigned TB_ENERGY_MAX = (64'd1 << TB_ENERGY_W) - 1;

typedef struct packed {
  rcea_pkg::rep_t           repetitions;
  logic [TB_ENERGY_W-1:0]   energy;
  logic                     up_flag;
} tally_t;

class lift_book;
  logic [15:0]                    reg_val [8];
  logic signed [TB_SAMPLE_W-1:0]  kept_distance;
  logic [TB_ENERGY_W-1:0]         energy_sum;
  rcea_pkg::rep_t                 reps;
  rcea_pkg::half_t                half_reps;
  bit                             up;
  tally_t                         owed [$];
  int                             mismatches;

  function new();
    reg_val[rcea_pkg::REG_HIGH_LIMIT]     = rcea_pkg::HIGH_LIMIT_RST;
    reg_val[rcea_pkg::REG_LOW_LIMIT]      = rcea_pkg::LOW_LIMIT_RST;
    reg_val[rcea_pkg::REG_VEL_HIGH_LIMIT] = rcea_pkg::VEL_HIGH_LIMIT_RST;
    reg_val[rcea_pkg::REG_VEL_LOW_LIMIT]  = rcea_pkg::VEL_LOW_LIMIT_RST;
    reg_val[rcea_pkg::REG_DEAD_BAND]      = 16'(rcea_pkg::DEAD_BAND_RST);
    reg_val[rcea_pkg::REG_LOAD_MASS]      = 16'(rcea_pkg::LOAD_MASS_RST);
    reg_val[rcea_pkg::REG_GRAVITY_ACCEL]  = 16'(rcea_pkg::GRAVITY_ACCEL_RST);
    reg_val[rcea_pkg::REG_DOWN_COEF]      = rcea_pkg::DOWN_COEF_RST;
    kept_distance = '0;
    energy_sum    = '0;
    reps          = '0;
    half_reps     = '0;
    up            = 1'b0;
    mismatches    = 0;
  endfunction

  function void write_reg(logic [rcea_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
    logic [15:0] keep;
    case (idx)
      rcea_pkg::REG_DEAD_BAND:     keep = 16'((32'd1 << rcea_pkg::DB_W) - 1);
      rcea_pkg::REG_LOAD_MASS:     keep = 16'((32'd1 << rcea_pkg::MASS_W) - 1);
      rcea_pkg::REG_GRAVITY_ACCEL: keep = 16'((32'd1 << rcea_pkg::ACCEL_W) - 1);
      default:                     keep = 16'hFFFF;
    endcase
    reg_val[idx] = data & keep;
  endfunction

  function void add_energy(longint unsigned amount);
    longint unsigned room;
    room = TB_ENERGY_MAX - longint'(energy_sum);
    if (amount > room) energy_sum = '1;
    else energy_sum = energy_sum + amount[TB_ENERGY_W-1:0];
  endfunction

  function void log_sample(logic o, logic signed [TB_SAMPLE_W-1:0] s);
    int                            step;
    longint unsigned               mag;
    longint unsigned               work;
    logic signed [TB_SAMPLE_W-1:0] rise_at;
    logic signed [TB_SAMPLE_W-1:0] fall_at;
    tally_t                        t;
    if (o == rcea_pkg::OP_DISTANCE) begin
      rise_at = reg_val[rcea_pkg::REG_HIGH_LIMIT];
      fall_at = reg_val[rcea_pkg::REG_LOW_LIMIT];
      step = int'(s) - int'(kept_distance);
      mag = (step < 0) ? longint'(-step) : longint'(step);
      if (mag > longint'(reg_val[rcea_pkg::REG_DEAD_BAND])) begin
        work = longint'(reg_val[rcea_pkg::REG_LOAD_MASS]) *
               longint'(reg_val[rcea_pkg::REG_GRAVITY_ACCEL]) * mag;
        if (step < 0)
          work = (work * longint'(reg_val[rcea_pkg::REG_DOWN_COEF])) >> rcea_pkg::COEF_FRAC;
        kept_distance = s;
        add_energy(work);
      end
      if (!up && s >= rise_at) begin
        if (reps != rcea_pkg::REP_MAX) reps = reps + 1'b1;
        up = 1'b1;
      end
      if (up && s <= fall_at) up = 1'b0;
    end else begin
      rise_at = reg_val[rcea_pkg::REG_VEL_HIGH_LIMIT];
      fall_at = reg_val[rcea_pkg::REG_VEL_LOW_LIMIT];
      if (!up && s >= rise_at) begin
        if (half_reps != rcea_pkg::HALF_MAX) half_reps = half_reps + 1'b1;
        up = 1'b1;
      end
      if (up && s <= fall_at) up = 1'b0;
      reps = rcea_pkg::rep_t'(half_reps >> 1);
    end
    t.repetitions = reps;
    t.energy      = energy_sum;
    t.up_flag     = up;
    owed.push_back(t);
  endfunction

  task report(string what);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task check_tally(rcea_pkg::rep_t r, logic [TB_ENERGY_W-1:0] e, logic f);
    tally_t want;
    if (owed.size() == 0) begin
      report("result beat with nothing pending");
    end else begin
      want = owed.pop_front();
      if (r !== want.repetitions)
        report($sformatf("repetitions got %0d want %0d", r, want.repetitions));
      if (e !== want.energy)
        report($sformatf("energy got %0d want %0d", e, want.energy));
      if (f !== want.up_flag)
        report($sformatf("up_flag got %0b want %0b", f, want.up_flag));
    end
  endtask
endclass

module tb_repetition_counter_energy_accumulator_unit;
  import rcea_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int PHASE_ITEMS = 104;

  typedef enum int {RX_FREE, RX_CHOPPY, RX_PERIODIC, RX_CLOGGED} rx_mode_e;
  typedef enum int {
    PROF_TYPICAL, PROF_TOP, PROF_BOTTOM, PROF_HEAVY, PROF_WILD, PROF_INVERTED
  } profile_e;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                 take_ready = 1'b0;

  rcea_in_if  #(.SAMPLE_WIDTH(TB_SAMPLE_W)) in_ch ();
  rcea_out_if #(.ENERGY_WIDTH(TB_ENERGY_W)) out_ch ();

  assign out_ch.ready = take_ready;

  repetition_counter_energy_accumulator_unit #(
    .SAMPLE_WIDTH(TB_SAMPLE_W),
    .ENERGY_WIDTH(TB_ENERGY_W)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lift_book book = new();
  int       sent;
  int       burst_left;
  bit       steady;
  rx_mode_e rx_mode = RX_FREE;
  int       rx_left;
  int       rx_tick;
  int       quiet;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(16, 160);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FREE:     take_ready <= 1'b1;
      RX_CHOPPY:   take_ready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: take_ready <= ((rx_tick % 5) < 2);
      default:     take_ready <= ($urandom_range(0, 11) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      book.check_tally(out_ch.repetitions, out_ch.energy, out_ch.up_flag);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("repetition_counter_energy_accumulator_unit test failed");
      $finish;
    end
  end

  function automatic logic signed [TB_SAMPLE_W-1:0] clamp16(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[TB_SAMPLE_W-1:0];
  endfunction

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      if (!steady) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_sample(input logic o, input logic signed [TB_SAMPLE_W-1:0] s);
    in_ch.valid  <= 1'b1;
    in_ch.op     <= o;
    in_ch.sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    book.log_sample(o, s);
    sent++;
    pace();
  endtask

  // hold off until every pending result beat is back
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (book.owed.size() != 0);
  endtask

  task automatic load_profile(input profile_e p);
    logic [15:0] v [8];
    int          h;
    int          k;
    case (p)
      PROF_TYPICAL: begin
        h = $urandom_range(200, 1500);
        v[REG_HIGH_LIMIT] = 16'(h);
        v[REG_LOW_LIMIT]  = 16'(h - int'($urandom_range(0, 400)));
        h = $urandom_range(100, 800);
        v[REG_VEL_HIGH_LIMIT] = 16'(h);
        v[REG_VEL_LOW_LIMIT]  = 16'(h - int'($urandom_range(50, 900)));
        v[REG_DEAD_BAND]      = 16'($urandom_range(0, 60));
        v[REG_LOAD_MASS]      = 16'($urandom_range(0, 10000));
        v[REG_GRAVITY_ACCEL]  = 16'($urandom_range(9000, 20000));
        v[REG_DOWN_COEF]      = 16'($urandom_range(0, 512));
      end
      PROF_TOP: begin
        v[REG_HIGH_LIMIT]     = 16'h7FFF;
        v[REG_LOW_LIMIT]      = 16'h7FFF;
        v[REG_VEL_HIGH_LIMIT] = 16'h7FFF;
        v[REG_VEL_LOW_LIMIT]  = 16'h7FFF;
        v[REG_DEAD_BAND]      = 16'h03FF;
        v[REG_LOAD_MASS]      = 16'h3FFF;
        v[REG_GRAVITY_ACCEL]  = 16'h7FFF;
        v[REG_DOWN_COEF]      = 16'hFFFF;
      end
      PROF_BOTTOM: begin
        v[REG_HIGH_LIMIT]     = 16'h8000;
        v[REG_LOW_LIMIT]      = 16'h8000;
        v[REG_VEL_HIGH_LIMIT] = 16'h8000;
        v[REG_VEL_LOW_LIMIT]  = 16'h8000;
        v[REG_DEAD_BAND]      = 16'h0000;
        v[REG_LOAD_MASS]      = 16'h0000;
        v[REG_GRAVITY_ACCEL]  = 16'h0000;
        v[REG_DOWN_COEF]      = 16'h0000;
      end
      PROF_HEAVY: begin
        v[REG_HIGH_LIMIT]     = 16'd1000;
        v[REG_LOW_LIMIT]      = 16'd200;
        v[REG_VEL_HIGH_LIMIT] = 16'd500;
        v[REG_VEL_LOW_LIMIT]  = 16'hFE0C;
        v[REG_DEAD_BAND]      = 16'h0000;
        v[REG_LOAD_MASS]      = 16'h3FFF;
        v[REG_GRAVITY_ACCEL]  = 16'h7FFF;
        v[REG_DOWN_COEF]      = 16'hFFFF;
      end
      PROF_INVERTED: begin
        v[REG_HIGH_LIMIT]     = 16'd300;
        v[REG_LOW_LIMIT]      = 16'd700;
        v[REG_VEL_HIGH_LIMIT] = 16'hFF9C;
        v[REG_VEL_LOW_LIMIT]  = 16'd100;
        v[REG_DEAD_BAND]      = 16'd5;
        v[REG_LOAD_MASS]      = 16'd200;
        v[REG_GRAVITY_ACCEL]  = 16'd9810;
        v[REG_DOWN_COEF]      = 16'd128;
      end
      default: begin
        foreach (v[k]) v[k] = 16'($urandom_range(0, 65535));
      end
    endcase
    for (k = 0; k < NUM_REGS; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(k);
      cfg_data  <= v[k];
      @(posedge clk);
      book.write_reg(CFG_IDX_W'(k), v[k]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    logic [16:0] plan [23];
    int          k;
    plan = '{
      {OP_DISTANCE, 16'd0},     {OP_DISTANCE, 16'd20},    {OP_DISTANCE, 16'd21},
      {OP_DISTANCE, 16'd499},   {OP_DISTANCE, 16'd500},   {OP_DISTANCE, 16'd101},
      {OP_DISTANCE, 16'd100},   {OP_DISTANCE, 16'h7FFF},  {OP_DISTANCE, 16'h8000},
      {OP_DISTANCE, 16'h7FFF},  {OP_DISTANCE, 16'd100},   {OP_VELOCITY, 16'd299},
      {OP_VELOCITY, 16'd300},   {OP_VELOCITY, 16'd51},    {OP_VELOCITY, 16'd50},
      {OP_VELOCITY, 16'h7FFF},  {OP_VELOCITY, 16'h8000},  {OP_VELOCITY, 16'd300},
      {OP_DISTANCE, 16'd600},   {OP_DISTANCE, 16'd0},     {OP_DISTANCE, 16'hFFFF},
      {OP_DISTANCE, 16'h8000},  {OP_VELOCITY, 16'd0}
    };
    for (k = 0; k < 23; k++) send_sample(plan[k][16], plan[k][15:0]);
  endtask

  // up-and-down swing across both limits of the selected mode
  task automatic swing(input logic o);
    logic signed [TB_SAMPLE_W-1:0] rise_at;
    logic signed [TB_SAMPLE_W-1:0] fall_at;
    int bottom, top, n, k, jit;
    if (o == OP_DISTANCE) begin
      rise_at = book.reg_val[REG_HIGH_LIMIT];
      fall_at = book.reg_val[REG_LOW_LIMIT];
    end else begin
      rise_at = book.reg_val[REG_VEL_HIGH_LIMIT];
      fall_at = book.reg_val[REG_VEL_LOW_LIMIT];
    end
    jit    = $urandom_range(0, 300);
    bottom = int'(fall_at) - jit;
    jit    = $urandom_range(0, 300);
    top    = int'(rise_at) + jit;
    n = $urandom_range(1, 6);
    for (k = 1; k <= n; k++) begin
      jit = $urandom_range(0, 40);
      send_sample(o, clamp16(bottom + (top - bottom) * k / n + jit - 20));
    end
    n = $urandom_range(1, 6);
    for (k = 1; k <= n; k++) begin
      jit = $urandom_range(0, 40);
      send_sample(o, clamp16(top - (top - bottom) * k / n + jit - 20));
    end
  endtask

  task automatic noise_burst();
    int                            n, k, pick, band, v;
    logic                          o;
    logic signed [TB_SAMPLE_W-1:0] s;
    n = $urandom_range(1, 4);
    for (k = 0; k < n; k++) begin
      o    = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 9);
      band = int'(book.reg_val[REG_DEAD_BAND]) + int'($urandom_range(0, 1));
      case (pick)
        0: s = 16'sh7FFF;
        1: s = 16'sh8000;
        2, 3: begin
          v = ($urandom_range(0, 1) != 0) ? band : -band;
          s = clamp16(int'(book.kept_distance) + v);
          o = OP_DISTANCE;
        end
        default: s = 16'($urandom_range(0, 65535));
      endcase
      send_sample(o, s);
    end
  endtask

  task automatic run_phase(input int budget, input bit force_drain);
    int start;
    int kind;
    start  = sent;
    steady = ($urandom_range(0, 3) == 0);
    while (sent - start < budget) begin
      if (force_drain && (sent - start) >= budget / 2) begin
        force_drain = 1'b0;
        settle();
      end else if ($urandom_range(0, 99) < 2) begin
        settle();
      end
      kind = $urandom_range(0, 99);
      if (kind < 45) swing(OP_DISTANCE);
      else if (kind < 70) swing(OP_VELOCITY);
      else noise_burst();
    end
  endtask

  initial begin
    profile_e order [8];
    int       k;
    order = '{PROF_TYPICAL, PROF_TOP, PROF_HEAVY, PROF_INVERTED,
              PROF_WILD, PROF_BOTTOM, PROF_TYPICAL, PROF_WILD};
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.op     <= OP_DISTANCE;
    in_ch.sample <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    for (k = 0; k < 8; k++) begin
      settle();
      load_profile(order[k]);
      run_phase(PHASE_ITEMS, k == 1);
    end
    settle();
    repeat (64) @(posedge clk);
    if (book.mismatches == 0) begin
      $display("repetition_counter_energy_accumulator_unit test passed");
    end else begin
      $display("repetition_counter_energy_accumulator_unit test failed");
    end
    $finish;
  end
endmodule

FILE: files.f
+incdir+sv
sv/rcea_pkg.sv
sv/rcea_if.sv
sv/repetition_counter_energy_accumulator_unit.sv
tb/tb_repetition_counter_energy_accumulator_unit.sv
